### sv/cst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coordinate set table package
// Opcodes, status codes and the beat types of the request and result
// channels.
// ----------------------------------------------------------------------------
package cst_pkg;

  // Request opcodes.
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_FIND   = 3'd2;
  localparam logic [2:0] OP_READ   = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  // Result status codes.
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_DUP    = 3'd2;
  localparam logic [2:0] ST_ABSENT = 3'd3;
  localparam logic [2:0] ST_RANGE  = 3'd4;

  // One request beat.
  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] row;
    logic [7:0] col;
    logic [5:0] index;
  } in_t;

  // One result beat.
  typedef struct packed {
    logic [2:0] status;
    logic [5:0] found_index;
    logic [7:0] row_out;
    logic [7:0] col_out;
    logic [6:0] count;
  } out_t;

endpackage

### sv/cst_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module cst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/cst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coordinate set table sequencer
// Runs one request at a time against the entry RAM: a pipelined linear
// search, the append for insert, the shift-down pass for remove, and the
// indexed read. Holds the fill count.
// ----------------------------------------------------------------------------
module cst_ctrl #(
  parameter int CAPACITY   = 64,
  parameter int COORD_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          req_accept,
  input  cst_pkg::in_t                  req,
  output logic                          idle,
  output logic                          res_valid,
  input  logic                          res_take,
  output cst_pkg::out_t                 res,
  output logic                          mem_wr_en,
  output logic [$clog2(CAPACITY)-1:0]   mem_wr_addr,
  output logic [2*COORD_BITS-1:0]       mem_wr_data,
  output logic                          mem_rd_en,
  output logic [$clog2(CAPACITY)-1:0]   mem_rd_addr,
  input  logic [2*COORD_BITS-1:0]       mem_rd_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int FW = $clog2(CAPACITY + 1);
  localparam int CB = COORD_BITS;
  localparam int KW = 2 * COORD_BITS;

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_RDWAIT = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [FW-1:0] ptr_r, ptr_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pidx_r, pidx_nxt;
  logic [2:0]    op_r, op_nxt;
  logic [KW-1:0] key_r, key_nxt;
  logic [2:0]    status_r, status_nxt;
  logic [5:0]    fidx_r, fidx_nxt;
  logic [7:0]    row_r, row_nxt;
  logic [7:0]    col_r, col_nxt;

  logic [KW-1:0] req_key;
  logic          read_bad;
  logic          hit;
  logic          more;

  // The pair as stored: row in the high half, column in the low half.
  assign req_key  = {CB'(req.row), CB'(req.col)};
  assign read_bad = (32'(req.index) >= 32'(fill_r)) || (32'(req.index) >= 32'(CAPACITY));
  assign hit      = pend_r && (mem_rd_data == key_r);
  assign more     = (ptr_r < fill_r);

  // Sequencer next state and RAM port control.
  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    ptr_nxt     = ptr_r;
    pend_nxt    = 1'b0;
    pidx_nxt    = pidx_r;
    op_nxt      = op_r;
    key_nxt     = key_r;
    status_nxt  = status_r;
    fidx_nxt    = fidx_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    mem_wr_en   = 1'b0;
    mem_wr_addr = fill_r[AW-1:0];
    mem_wr_data = key_r;
    mem_rd_en   = 1'b0;
    mem_rd_addr = ptr_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (req_accept) begin
          op_nxt     = req.opcode;
          key_nxt    = req_key;
          ptr_nxt    = '0;
          status_nxt = cst_pkg::ST_OK;
          fidx_nxt   = '0;
          row_nxt    = '0;
          col_nxt    = '0;
          state_nxt  = S_RESP;
          case (req.opcode) inside
            cst_pkg::OP_INSERT: begin
              if (fill_r == FW'(CAPACITY)) begin
                status_nxt = cst_pkg::ST_FULL;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            cst_pkg::OP_REMOVE, cst_pkg::OP_FIND: begin
              state_nxt = S_SCAN;
            end
            cst_pkg::OP_READ: begin
              if (read_bad) begin
                status_nxt = cst_pkg::ST_RANGE;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = AW'(req.index);
                state_nxt   = S_RDWAIT;
              end
            end
            cst_pkg::OP_CLEAR: begin
              fill_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // Issue one read per cycle and compare the entry read the cycle before.
      S_SCAN: begin
        if (hit) begin
          state_nxt = S_RESP;
          case (op_r)
            cst_pkg::OP_INSERT: status_nxt = cst_pkg::ST_DUP;
            cst_pkg::OP_FIND:   fidx_nxt   = 6'(pidx_r);
            default: begin
              ptr_nxt   = FW'(pidx_r) + FW'(1);
              state_nxt = S_SHIFT;
            end
          endcase
        end else if (more) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = ptr_r[AW-1:0];
          pend_nxt    = 1'b1;
          pidx_nxt    = ptr_r[AW-1:0];
          ptr_nxt     = ptr_r + FW'(1);
        end else begin
          state_nxt = S_RESP;
          if (op_r == cst_pkg::OP_INSERT) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = fill_r[AW-1:0];
            mem_wr_data = key_r;
            fill_nxt    = fill_r + FW'(1);
          end else begin
            status_nxt = cst_pkg::ST_ABSENT;
          end
        end
      end

      // Move each later entry down one place: read at ptr, write at ptr - 1.
      S_SHIFT: begin
        if (pend_r) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = pidx_r - AW'(1);
          mem_wr_data = mem_rd_data;
        end
        if (more) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = ptr_r[AW-1:0];
          pend_nxt    = 1'b1;
          pidx_nxt    = ptr_r[AW-1:0];
          ptr_nxt     = ptr_r + FW'(1);
        end else if (!pend_r) begin
          fill_nxt  = fill_r - FW'(1);
          state_nxt = S_RESP;
        end
      end

      // Indexed read data arrives in the cycle after the address.
      S_RDWAIT: begin
        row_nxt   = 8'(mem_rd_data[KW-1:CB]);
        col_nxt   = 8'(mem_rd_data[CB-1:0]);
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    pidx_r   <= pidx_nxt;
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    status_r <= status_nxt;
    fidx_r   <= fidx_nxt;
    row_r    <= row_nxt;
    col_r    <= col_nxt;
  end

  // Result beat; the count is taken after the request has updated it.
  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESP);
  always_comb begin
    res.status      = status_r;
    res.found_index = fidx_r;
    res.row_out     = row_r;
    res.col_out     = col_r;
    res.count       = 7'(fill_r);
  end

endmodule

### sv/coordinate_set_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coordinate set table
// Insertion-ordered set of up to CAPACITY (row, column) pairs with insert,
// remove, find, indexed read and clear.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat on in_data (opcode, row, col, index) is taken when
//   in_valid is high and in_stall is low. Exactly one result beat follows
//   on out_data (status, found_index, row_out, col_out, count), taken when
//   out_valid is high and out_stall is low.
//   Requests are handled one at a time. Insert and find run a linear search
//   through the entry RAM; remove runs the search, then a shift-down pass
//   one entry per cycle over the RAM's read and write ports; read at index
//   is a single RAM read; clear, spare opcodes, an insert into a full set
//   and an out-of-range read go straight to the result. The next request
//   is taken no sooner than the edge at which the previous result can
//   first be taken.
//   A result is held in an output register, so while the receiver stalls,
//   the next request is accepted and worked on; it then waits until the
//   held beat is taken.
//   Reset empties the set at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module coordinate_set_table_core #(
  parameter int CAPACITY   = 64,
  parameter int COORD_BITS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cst_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output cst_pkg::out_t out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int KW = 2 * COORD_BITS;

  logic          idle;
  logic          in_accept;
  logic          res_valid;
  logic          res_take;
  cst_pkg::out_t res;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [KW-1:0] mem_wr_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic [KW-1:0] mem_rd_data;

  logic          out_valid_r, out_valid_nxt;
  cst_pkg::out_t out_data_r;

  assign in_stall  = !idle;
  assign in_accept = in_valid && !in_stall;

  // Sequencer.
  cst_ctrl #(
    .CAPACITY   (CAPACITY),
    .COORD_BITS (COORD_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_accept  (in_accept),
    .req         (in_data),
    .idle        (idle),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res         (res),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  // Entry storage.
  cst_ram #(
    .WIDTH (KW),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Output register: loads when empty or when its beat leaves this cycle.
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sv/cst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coordinate set table port checker
// Watches the top level's ports and flags behavior the block must never show.
// ----------------------------------------------------------------------------
module cst_checker #(
  parameter int CAPACITY = 64
) (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input cst_pkg::out_t out_data
);

  // Requests are served one at a time: an accepted beat makes the port busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request port not busy after an accepted beat");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result beat changed");

  // A refused or failed request carries no position and no pair.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != cst_pkg::ST_OK)) |->
    (out_data.found_index == 6'd0 && out_data.row_out == 8'd0 &&
     out_data.col_out == 8'd0))
    else $error("failed request reported data");

  // Full is only reported when the set holds CAPACITY pairs.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == cst_pkg::ST_FULL)) |->
    (out_data.count == 7'(CAPACITY)))
    else $error("full status with a count below capacity");

  // An out-of-range read carries no pair.
  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == cst_pkg::ST_RANGE)) |->
    (out_data.row_out == 8'd0 && out_data.col_out == 8'd0))
    else $error("out-of-range read returned a pair");

endmodule

bind coordinate_set_table_core cst_checker #(
  .CAPACITY (CAPACITY)
) u_cst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### tb/sv/cst_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coordinate set table result checker
// Watches the request and result channels of the coordinate set table. Each
// accepted request beat runs through a local model of the table, and the
// result it should produce is queued. Each accepted result beat is compared
// field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module cst_result_checker #(
  parameter int CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  cst_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  cst_pkg::out_t out_data,
  output int unsigned   fail_count,
  output int unsigned   pending,
  output int unsigned   checked
);

  // Local copy of the table: pairs packed as {row, col}, in insertion order.
  logic [15:0]   table_pairs [CAPACITY];
  int unsigned   pair_count = 0;
  cst_pkg::out_t results_due [$];
  int unsigned   fails = 0;
  int unsigned   results_seen = 0;

  // Position of a pair among the held ones, or pair_count when it is absent.
  function automatic int unsigned locate_pair(logic [15:0] key);
    int unsigned pos;
    pos = pair_count;
    for (int unsigned i = 0; i < pair_count; i++) begin
      if (table_pairs[i] == key && pos == pair_count) begin
        pos = i;
      end
    end
    return pos;
  endfunction

  // Apply one request to the local table and return the result it gives.
  function automatic cst_pkg::out_t apply_request(cst_pkg::in_t req);
    cst_pkg::out_t res;
    logic [15:0]   key;
    int unsigned   pos;
    res = '0;
    key = {req.row, req.col};
    pos = locate_pair(key);
    case (req.opcode)
      cst_pkg::OP_INSERT: begin
        if (pair_count >= CAPACITY) begin
          res.status = cst_pkg::ST_FULL;
        end else if (pos < pair_count) begin
          res.status = cst_pkg::ST_DUP;
        end else begin
          table_pairs[pair_count] = key;
          pair_count++;
        end
      end
      cst_pkg::OP_REMOVE: begin
        if (pos >= pair_count) begin
          res.status = cst_pkg::ST_ABSENT;
        end else begin
          // Close the gap: every later pair moves down one place.
          for (int unsigned i = pos; i + 1 < pair_count; i++) begin
            table_pairs[i] = table_pairs[i + 1];
          end
          pair_count--;
        end
      end
      cst_pkg::OP_FIND: begin
        if (pos >= pair_count) begin
          res.status = cst_pkg::ST_ABSENT;
        end else begin
          res.found_index = pos[5:0];
        end
      end
      cst_pkg::OP_READ: begin
        if (req.index >= pair_count) begin
          res.status = cst_pkg::ST_RANGE;
        end else begin
          {res.row_out, res.col_out} = table_pairs[req.index];
        end
      end
      cst_pkg::OP_CLEAR: begin
        pair_count = 0;
      end
      default: begin
        // Spare opcodes leave the table alone and report zeros apart from the count.
      end
    endcase
    res.count = pair_count[6:0];
    return res;
  endfunction

  // One line per mismatch, and a count of them all.
  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    fails++;
    $display("[%0t] result beat %0d: %s is %0d, should be %0d",
             $time, results_seen, what, got, want);
  endtask

  task automatic compare_result(cst_pkg::out_t got, cst_pkg::out_t want);
    if (got.status !== want.status) begin
      report_mismatch("status", 32'(got.status), 32'(want.status));
    end
    if (got.found_index !== want.found_index) begin
      report_mismatch("found_index", 32'(got.found_index), 32'(want.found_index));
    end
    if (got.row_out !== want.row_out) begin
      report_mismatch("row_out", 32'(got.row_out), 32'(want.row_out));
    end
    if (got.col_out !== want.col_out) begin
      report_mismatch("col_out", 32'(got.col_out), 32'(want.col_out));
    end
    if (got.count !== want.count) begin
      report_mismatch("count", 32'(got.count), 32'(want.count));
    end
  endtask

  // Results are taken before requests: a result beat always belongs to a
  // request accepted at an earlier edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      pair_count = 0;
      results_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          report_mismatch("beats with no request waiting", 1, 0);
        end else begin
          compare_result(out_data, results_due.pop_front());
        end
        results_seen++;
      end
      if (in_valid && !in_stall) begin
        results_due.push_back(apply_request(in_data));
      end
    end
    fail_count <= fails;
    pending    <= results_due.size();
    checked    <= results_seen;
  end

endmodule

### tb/sv/tb_coordinate_set_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coordinate set table testbench
// Drives request beats into the coordinate set table: a short directed run
// over the edge cases, a fill to capacity, then a long random mix of
// well-formed requests with some noise. Both channels idle at random, and
// the receiver once holds off long enough to back the request side up. A
// separate checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_coordinate_set_table_core;

  localparam int SET_CAP      = 64;
  localparam int ITEMS        = 1950;
  localparam int QUIET_TAIL   = 200;
  localparam int BLOCK_ITEMS  = 150;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 250;
  localparam int DRAIN_CYCLES = SET_CAP + 20;
  localparam int STALL_LIMIT  = 2000;

  // Opcodes the block does not use; it must ignore them.
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  cst_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall;
  cst_pkg::out_t out_data;
  int unsigned   fail_count;
  int unsigned   pending;
  int unsigned   checked;

  // Stimulus-side view of the pairs held, used to aim requests and track the peak fill.
  logic [15:0] held_keys [$];
  int unsigned sent = 0;
  int unsigned peak_fill = 0;
  bit          quiet = 1'b0;
  bit          sender_calm = 1'b0;
  bit          hold_wanted = 1'b0;

  coordinate_set_table_core #(
    .CAPACITY  (SET_CAP),
    .COORD_BITS(8)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  cst_result_checker #(
    .CAPACITY(SET_CAP)
  ) u_result_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: too long without a beat on either channel ends the run.
  initial begin
    int unsigned idle_run;
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_run = 0;
      end else begin
        idle_run++;
      end
    end
    $display("Watchdog: %0d cycles without a beat.", STALL_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // Result receiver: calm stretches, short stall bursts, and one long hold.
  initial begin
    int unsigned span;
    forever begin
      if (hold_wanted) begin
        out_stall   <= 1'b1;
        span        = HOLD_CYCLES;
        hold_wanted = 1'b0;
      end else if (quiet || $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b0;
        span      = $urandom_range(5, 40);
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        span      = $urandom_range(1, 5);
      end else begin
        out_stall <= 1'b0;
        span      = $urandom_range(1, 6);
      end
      repeat (span) @(posedge clk);
    end
  end

  function automatic cst_pkg::in_t make_beat(logic [2:0] op, logic [7:0] r,
                                             logic [7:0] c, logic [5:0] idx);
    cst_pkg::in_t beat;
    beat.opcode = op;
    beat.row    = r;
    beat.col    = c;
    beat.index  = idx;
    return beat;
  endfunction

  function automatic int held_pos(logic [15:0] key);
    foreach (held_keys[i]) begin
      if (held_keys[i] == key) begin
        return i;
      end
    end
    return -1;
  endfunction

  // Keep the stimulus-side view in step with each request sent.
  function automatic void track_beat(cst_pkg::in_t beat);
    int pos;
    pos = held_pos({beat.row, beat.col});
    case (beat.opcode)
      cst_pkg::OP_INSERT: begin
        if (pos < 0 && held_keys.size() < SET_CAP) begin
          held_keys.push_back({beat.row, beat.col});
        end
      end
      cst_pkg::OP_REMOVE: begin
        if (pos >= 0) begin
          held_keys.delete(pos);
        end
      end
      cst_pkg::OP_CLEAR: begin
        held_keys.delete();
      end
      default: begin
      end
    endcase
    if (held_keys.size() > peak_fill) begin
      peak_fill = held_keys.size();
    end
  endfunction

  // Offer one request beat, after an optional idle burst, and wait for it.
  task automatic send_beat(cst_pkg::in_t beat);
    int unsigned gap;
    if (!quiet && !sender_calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(posedge clk);
    end
    in_data  <= beat;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    track_beat(beat);
    if (beat.opcode <= cst_pkg::OP_CLEAR) begin
      sent++;
    end
  endtask

  // Random request, aimed at held pairs often enough to reach every case.
  function automatic cst_pkg::in_t pick_request(bit growing);
    int unsigned roll;
    logic [15:0] fresh;
    logic [15:0] held;
    logic [15:0] key;
    logic [5:0]  idx;
    roll  = $urandom_range(0, 99);
    fresh = 16'($urandom);
    held  = (held_keys.size() > 0) ?
            held_keys[$urandom_range(0, held_keys.size() - 1)] : fresh;
    idx   = 6'($urandom);
    if (roll < (growing ? 70 : 35)) begin
      key = ($urandom_range(0, 4) == 0) ? held : fresh;
      return make_beat(cst_pkg::OP_INSERT, key[15:8], key[7:0], idx);
    end else if (roll < (growing ? 80 : 57)) begin
      key = ($urandom_range(0, 3) == 0) ? fresh : held;
      return make_beat(cst_pkg::OP_REMOVE, key[15:8], key[7:0], idx);
    end else if (roll < (growing ? 89 : 78)) begin
      key = ($urandom_range(0, 3) == 0) ? fresh : held;
      return make_beat(cst_pkg::OP_FIND, key[15:8], key[7:0], idx);
    end else if (growing || roll < 99) begin
      if (held_keys.size() > 0 && $urandom_range(0, 1) == 0) begin
        idx = 6'($urandom_range(0, held_keys.size() - 1));
      end
      return make_beat(cst_pkg::OP_READ, fresh[15:8], fresh[7:0], idx);
    end
    return make_beat(cst_pkg::OP_CLEAR, fresh[15:8], fresh[7:0], idx);
  endfunction

  // Stimulus and verdict.
  initial begin
    bit           hold_done;
    bit           growing;
    cst_pkg::in_t beat;
    hold_done = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, duplicates, extremes, shifts, spare opcodes.
    send_beat(make_beat(cst_pkg::OP_READ,   8'd0,   8'd0,   6'd0));
    send_beat(make_beat(cst_pkg::OP_FIND,   8'd12,  8'd34,  6'd0));
    send_beat(make_beat(cst_pkg::OP_REMOVE, 8'd12,  8'd34,  6'd0));
    send_beat(make_beat(cst_pkg::OP_INSERT, 8'd0,   8'd0,   6'd0));
    send_beat(make_beat(cst_pkg::OP_INSERT, 8'd255, 8'd255, 6'd63));
    send_beat(make_beat(cst_pkg::OP_INSERT, 8'd0,   8'd0,   6'd0));
    send_beat(make_beat(cst_pkg::OP_INSERT, 8'd255, 8'd0,   6'd0));
    send_beat(make_beat(cst_pkg::OP_INSERT, 8'd0,   8'd255, 6'd0));
    send_beat(make_beat(cst_pkg::OP_FIND,   8'd255, 8'd255, 6'd0));
    send_beat(make_beat(cst_pkg::OP_FIND,   8'd0,   8'd255, 6'd0));
    send_beat(make_beat(cst_pkg::OP_READ,   8'd0,   8'd0,   6'd3));
    send_beat(make_beat(cst_pkg::OP_READ,   8'd0,   8'd0,   6'd4));
    send_beat(make_beat(cst_pkg::OP_READ,   8'd255, 8'd255, 6'd63));
    send_beat(make_beat(cst_pkg::OP_REMOVE, 8'd0,   8'd0,   6'd0));
    send_beat(make_beat(cst_pkg::OP_READ,   8'd0,   8'd0,   6'd0));
    send_beat(make_beat(cst_pkg::OP_FIND,   8'd0,   8'd255, 6'd0));
    send_beat(make_beat(cst_pkg::OP_REMOVE, 8'd0,   8'd255, 6'd0));
    send_beat(make_beat(cst_pkg::OP_REMOVE, 8'd255, 8'd0,   6'd0));
    send_beat(make_beat(cst_pkg::OP_REMOVE, 8'd255, 8'd0,   6'd0));
    for (logic [3:0] op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) begin
      send_beat(make_beat(op[2:0], 8'd255, 8'd255, 6'd63));
    end
    send_beat(make_beat(cst_pkg::OP_CLEAR,  8'd255, 8'd255, 6'd63));
    send_beat(make_beat(cst_pkg::OP_READ,   8'd0,   8'd0,   6'd0));
    send_beat(make_beat(cst_pkg::OP_CLEAR,  8'd0,   8'd0,   6'd0));

    // Fill to capacity, push past it, then remove at both ends.
    while (held_keys.size() < SET_CAP) begin
      send_beat(make_beat(cst_pkg::OP_INSERT, 8'($urandom), 8'($urandom),
                          6'($urandom)));
    end
    send_beat(make_beat(cst_pkg::OP_INSERT, 8'($urandom), 8'($urandom),
                        6'($urandom)));
    send_beat(make_beat(cst_pkg::OP_INSERT, held_keys[0][15:8], held_keys[0][7:0],
                        6'd0));
    send_beat(make_beat(cst_pkg::OP_READ, 8'd0, 8'd0, 6'd63));
    beat = make_beat(cst_pkg::OP_FIND, held_keys[SET_CAP - 1][15:8],
                     held_keys[SET_CAP - 1][7:0], 6'd0);
    send_beat(beat);
    send_beat(make_beat(cst_pkg::OP_REMOVE, held_keys[0][15:8], held_keys[0][7:0],
                        6'd0));
    beat = make_beat(cst_pkg::OP_REMOVE, held_keys[held_keys.size() - 1][15:8],
                     held_keys[held_keys.size() - 1][7:0], 6'd0);
    send_beat(beat);
    send_beat(make_beat(cst_pkg::OP_READ, 8'd0, 8'd0, 6'd62));
    send_beat(make_beat(cst_pkg::OP_READ, 8'd0, 8'd0, 6'd61));

    // Random mix in blocks: some grow the table toward full, others churn.
    while (sent < ITEMS) begin
      growing     = ((sent / BLOCK_ITEMS) % 3) == 1;
      sender_calm = ((sent / BLOCK_ITEMS) % 4) == 3;
      quiet       = sent >= ITEMS - QUIET_TAIL;
      if (!hold_done && sent >= HOLD_AT) begin
        hold_wanted = 1'b1;
        hold_done   = 1'b1;
      end
      if ($urandom_range(0, 49) == 0) begin
        beat = make_beat(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
                         8'($urandom), 8'($urandom), 6'($urandom));
      end else begin
        beat = pick_request(growing);
      end
      send_beat(beat);
    end
    in_valid <= 1'b0;

    // Drain: wait for every result, then some margin for strays.
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests (directed cases, a fill to capacity, random mix);",
             sent);
    $display("checked %0d result beats, peak fill %0d of %0d, one %0d-cycle hold.",
             checked, peak_fill, SET_CAP, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
